// ----- rtl/core/utf8sd_pkg.sv -----
// ----------------------------------------------------------------------------
// utf8sd_pkg: shared types and constants of the UTF-8 stream decoder
// Holds the channel payload structs, the byte class codes that the front
// hands to the back, and the code point limits used by the checks.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int MAXC_W      = 16;
    localparam int COUNT_W_DEF = 16;
    localparam int LEN_W       = 3;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_1BYTE   = 21'h00007F;
    localparam logic [CP_W-1:0] MAX_2BYTE   = 21'h0007FF;
    localparam logic [CP_W-1:0] MAX_3BYTE   = 21'h00FFFF;
    localparam logic [CP_W-1:0] MAX_SCALAR  = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;

    localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THR  = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

    // Class of one raw byte as seen by the front.
    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } byte_class_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            run_last;
        logic            string_done;
    } out_item_t;

    // Classified request as it travels through the queue.
    typedef struct packed {
        byte_class_t       cls;
        logic [BYTE_W-1:0] data;
        logic              eos;
    } q_item_t;

endpackage

// ----- rtl/core/utf8sd_front.sv -----
// ----------------------------------------------------------------------------
// utf8sd_front: input side of the UTF-8 stream decoder
// Accepts raw bytes, sorts each one into a byte class and pushes the
// classified request into the queue toward the back.
// ----------------------------------------------------------------------------
module utf8sd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  utf8sd_pkg::in_item_t s_data,
    input  logic                 q_ready,
    output logic                 q_push,
    output utf8sd_pkg::q_item_t  q_item
);

    utf8sd_pkg::byte_class_t cls;

    // Sort the byte by its leading bits.
    always_comb begin
        priority casez (s_data.in_byte)
            8'b0000_0000: cls = utf8sd_pkg::CLS_ZERO;
            8'b0???_????: cls = utf8sd_pkg::CLS_ASCII;
            8'b10??_????: cls = utf8sd_pkg::CLS_CONT;
            8'b110?_????: cls = utf8sd_pkg::CLS_LEAD2;
            8'b1110_????: cls = utf8sd_pkg::CLS_LEAD3;
            8'b1111_0???: cls = utf8sd_pkg::CLS_LEAD4;
            default:      cls = utf8sd_pkg::CLS_BAD;
        endcase
    end

    // A valid request enters the queue whenever the queue has room.
    assign s_ready     = q_ready;
    assign q_push      = s_valid && q_ready;
    assign q_item.cls  = cls;
    assign q_item.data = s_data.in_byte;
    assign q_item.eos  = s_data.end_of_string;

    // The front never pushes into a full queue.
    a_push_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> q_ready)
        else $error("front pushed while the queue had no room");

    a_eos_carried: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_item.eos == s_data.end_of_string) && (q_item.data == s_data.in_byte))
        else $error("front altered the request payload");

    a_zero_class: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && (s_data.in_byte == 8'h00) |-> (q_item.cls == utf8sd_pkg::CLS_ZERO))
        else $error("zero byte not classified as terminator");

endmodule

// ----- rtl/core/utf8sd_queue.sv -----
// ----------------------------------------------------------------------------
// utf8sd_queue: short queue between front and back
// A small circular buffer of classified requests so that the front and the
// back can each stall without holding up the other.
// ----------------------------------------------------------------------------
module utf8sd_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  utf8sd_pkg::q_item_t push_item,
    output logic                ready,
    input  logic                pop,
    output logic                valid,
    output utf8sd_pkg::q_item_t head
);

    utf8sd_pkg::q_item_t mem [utf8sd_pkg::Q_DEPTH];

    logic [utf8sd_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [utf8sd_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [utf8sd_pkg::Q_CNT_W-1:0] count_reg, count_next;

    assign ready = (count_reg != utf8sd_pkg::Q_CNT_W'(utf8sd_pkg::Q_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == utf8sd_pkg::Q_PTR_W'(utf8sd_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == utf8sd_pkg::Q_PTR_W'(utf8sd_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ready || pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= utf8sd_pkg::Q_CNT_W'(utf8sd_pkg::Q_DEPTH))
        else $error("queue fill count out of range");

endmodule

// ----- rtl/core/utf8sd_back.sv -----
// ----------------------------------------------------------------------------
// utf8sd_back: decoding side of the UTF-8 stream decoder
// Holds the pending sequence and the per-string count, turns classified
// requests into code points and drives the output register.
// ----------------------------------------------------------------------------
module utf8sd_back #(
    parameter int COUNT_WIDTH = utf8sd_pkg::COUNT_W_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [utf8sd_pkg::MAXC_W-1:0] max_chars,
    input  logic                          q_valid,
    input  utf8sd_pkg::q_item_t           q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output utf8sd_pkg::out_item_t         m_data
);

    localparam int CMP_W = (COUNT_WIDTH > utf8sd_pkg::MAXC_W) ? COUNT_WIDTH : utf8sd_pkg::MAXC_W;

    logic [utf8sd_pkg::CP_W-1:0]  pb_reg, pb_next;
    logic [utf8sd_pkg::LEN_W-1:0] be_reg, be_next;
    logic [utf8sd_pkg::LEN_W-1:0] br_reg, br_next;
    logic [COUNT_WIDTH-1:0]       cnt_reg, cnt_next;
    logic                         lim_reg, lim_next;
    logic                         out_valid_reg, out_valid_next;
    utf8sd_pkg::out_item_t        out_reg, out_next;

    logic                         step;
    logic                         ends;
    logic                         emit;
    logic                         emit_err;
    logic [utf8sd_pkg::CP_W-1:0]  emit_cp;
    logic                         emit_last;
    logic                         lim_cap;
    logic                         lim_hit;
    logic                         second_emits;
    logic [utf8sd_pkg::CP_W-1:0]  acc;
    logic [utf8sd_pkg::LEN_W-1:0] rcv;
    logic                         seq_ok;
    logic [COUNT_WIDTH-1:0]       cnt_inc;

    // One request is worked on whenever the output register can take a result.
    assign step = q_valid && (!out_valid_reg || m_ready);
    assign ends = (q_item.cls == utf8sd_pkg::CLS_ZERO) || q_item.eos;

    assign acc = {pb_reg[utf8sd_pkg::CP_W-7:0], q_item.data[5:0]};
    assign rcv = br_reg + 1'b1;

    // Range check of a completed sequence.
    always_comb begin
        unique case (be_reg)
            utf8sd_pkg::LEN_TWO: seq_ok = acc > utf8sd_pkg::MAX_1BYTE;
            utf8sd_pkg::LEN_THR: seq_ok = (acc > utf8sd_pkg::MAX_2BYTE) &&
                                          ((acc < utf8sd_pkg::SURR_LO) ||
                                           (acc > utf8sd_pkg::SURR_HI));
            default:             seq_ok = (acc > utf8sd_pkg::MAX_3BYTE) &&
                                          (acc <= utf8sd_pkg::MAX_SCALAR);
        endcase
    end

    // The breaking byte emits again as a lead byte if it is a single-byte
    // code, an invalid byte, or a lead byte that the end flag cuts short.
    assign second_emits = (q_item.cls == utf8sd_pkg::CLS_ASCII) ||
                          (q_item.cls == utf8sd_pkg::CLS_CONT)  ||
                          (q_item.cls == utf8sd_pkg::CLS_BAD)   || q_item.eos;

    // Saturating count and limit check for one emitted code point. The limit
    // test itself does not depend on whether a code point is emitted.
    assign cnt_inc = (cnt_reg == {COUNT_WIDTH{1'b1}}) ? cnt_reg : cnt_reg + 1'b1;
    assign lim_cap = (max_chars != '0) && (CMP_W'(cnt_inc) >= CMP_W'(max_chars));
    assign lim_hit = emit && lim_cap;

    // Decode step: at most one code point per cycle. A byte that breaks a pending
    // sequence stays at the queue head for a second pass unless the limit is hit.
    always_comb begin
        pb_next   = pb_reg;
        be_next   = be_reg;
        br_next   = br_reg;
        emit      = 1'b0;
        emit_err  = 1'b0;
        emit_cp   = utf8sd_pkg::REPLACEMENT;
        emit_last = 1'b1;
        q_pop     = 1'b0;
        if (step) begin
            if (lim_reg) begin
                q_pop = 1'b1;
            end else if (q_item.cls == utf8sd_pkg::CLS_ZERO) begin
                q_pop = 1'b1;
                if (be_reg != utf8sd_pkg::LEN_NONE) begin
                    emit     = 1'b1;
                    emit_err = 1'b1;
                end
            end else if (be_reg != utf8sd_pkg::LEN_NONE) begin
                if (q_item.cls == utf8sd_pkg::CLS_CONT) begin
                    q_pop   = 1'b1;
                    pb_next = acc;
                    br_next = rcv;
                    if (rcv >= be_reg) begin
                        emit     = 1'b1;
                        emit_err = !seq_ok;
                        emit_cp  = seq_ok ? acc : utf8sd_pkg::REPLACEMENT;
                        pb_next  = '0;
                        be_next  = utf8sd_pkg::LEN_NONE;
                        br_next  = utf8sd_pkg::LEN_NONE;
                    end else if (q_item.eos) begin
                        emit     = 1'b1;
                        emit_err = 1'b1;
                        pb_next  = '0;
                        be_next  = utf8sd_pkg::LEN_NONE;
                        br_next  = utf8sd_pkg::LEN_NONE;
                    end
                end else begin
                    // Missing continuation: replace the pending sequence.
                    emit      = 1'b1;
                    emit_err  = 1'b1;
                    pb_next   = '0;
                    be_next   = utf8sd_pkg::LEN_NONE;
                    br_next   = utf8sd_pkg::LEN_NONE;
                    q_pop     = lim_cap;
                    emit_last = lim_cap || !second_emits;
                end
            end else begin
                q_pop = 1'b1;
                unique case (q_item.cls)
                    utf8sd_pkg::CLS_ASCII: begin
                        emit    = 1'b1;
                        emit_cp = utf8sd_pkg::CP_W'(q_item.data);
                    end
                    utf8sd_pkg::CLS_LEAD2: begin
                        pb_next = utf8sd_pkg::CP_W'(q_item.data[4:0]);
                        be_next = utf8sd_pkg::LEN_TWO;
                        br_next = utf8sd_pkg::LEN_ONE;
                    end
                    utf8sd_pkg::CLS_LEAD3: begin
                        pb_next = utf8sd_pkg::CP_W'(q_item.data[3:0]);
                        be_next = utf8sd_pkg::LEN_THR;
                        br_next = utf8sd_pkg::LEN_ONE;
                    end
                    utf8sd_pkg::CLS_LEAD4: begin
                        pb_next = utf8sd_pkg::CP_W'(q_item.data[2:0]);
                        be_next = utf8sd_pkg::LEN_FOUR;
                        br_next = utf8sd_pkg::LEN_ONE;
                    end
                    default: begin
                        emit     = 1'b1;
                        emit_err = 1'b1;
                    end
                endcase
                // A lead byte that carries the end flag cannot complete.
                if (q_item.eos && !emit) begin
                    emit     = 1'b1;
                    emit_err = 1'b1;
                    pb_next  = '0;
                    be_next  = utf8sd_pkg::LEN_NONE;
                    br_next  = utf8sd_pkg::LEN_NONE;
                end
            end
        end
    end

    // Per-string count, limit and end-of-string clearing.
    always_comb begin
        cnt_next = cnt_reg;
        lim_next = lim_reg;
        if (emit) begin
            cnt_next = cnt_inc;
            lim_next = lim_hit;
        end
        if (q_pop && ends) begin
            cnt_next = '0;
            lim_next = 1'b0;
        end
    end

    // Output register: a new result loads when it is empty or the old one is taken.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next       = 1'b1;
            out_next.code_point  = emit_cp;
            out_next.is_error    = emit_err;
            out_next.run_last    = emit_last;
            out_next.string_done = emit_last && (ends || lim_hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pb_reg        <= '0;
            be_reg        <= utf8sd_pkg::LEN_NONE;
            br_reg        <= utf8sd_pkg::LEN_NONE;
            cnt_reg       <= '0;
            lim_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if ((q_pop && ends) || lim_next) begin
                pb_reg <= '0;
                be_reg <= utf8sd_pkg::LEN_NONE;
                br_reg <= utf8sd_pkg::LEN_NONE;
            end else begin
                pb_reg <= pb_next;
                be_reg <= be_next;
                br_reg <= br_next;
            end
            cnt_reg       <= cnt_next;
            lim_reg       <= lim_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_pending_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (be_reg != utf8sd_pkg::LEN_NONE) |->
            (br_reg != utf8sd_pkg::LEN_NONE) && (br_reg < be_reg))
        else $error("pending sequence byte count inconsistent");

    a_limit_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        lim_reg |-> (be_reg == utf8sd_pkg::LEN_NONE))
        else $error("sequence pending while the limit is reached");

    a_hold_only_on_break: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !q_pop |-> emit && emit_err && !lim_hit)
        else $error("request held without a replacement result");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.string_done |-> out_reg.run_last)
        else $error("string closed on a result that is not the last of its byte");

endmodule

// ----- rtl/core/utf8_stream_decoder.sv -----
// Data path: an accepted byte is written into the queue, the back takes it
// from the queue head, and its result is held in the output register.
// Throughput: one byte per cycle without output stalls; a byte that breaks
// a sequence gets a second pass below the limit: one code point per cycle.
// Reset (aresetn low, synchronous): queue, pending sequence, count, limit,
// output valid and max_chars all clear; no clearing pass is needed.
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming UTF-8 to code point decoder
// Front classifies bytes, a short queue decouples it from the back, which
// tracks the pending sequence and emits code points or U+FFFD.
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
    parameter int COUNT_WIDTH = utf8sd_pkg::COUNT_W_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [utf8sd_pkg::MAXC_W-1:0] cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  utf8sd_pkg::in_item_t          s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output utf8sd_pkg::out_item_t         m_data
);

    logic [utf8sd_pkg::MAXC_W-1:0] max_chars_reg;
    logic                          q_ready;
    logic                          q_push;
    utf8sd_pkg::q_item_t           q_push_item;
    logic                          q_valid;
    logic                          q_pop;
    utf8sd_pkg::q_item_t           q_head;

    // Configuration register: always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= '0;
        end else if (cfg_valid) begin
            max_chars_reg <= cfg_data;
        end
    end

    utf8sd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_item  (q_push_item)
    );

    utf8sd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    utf8sd_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_chars (max_chars_reg),
        .q_valid   (q_valid),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
